// ===== hw/rtl/ipv4ov_pkg.sv =====
package ipv4ov_pkg;

	localparam int MAX_OPT_BYTES = 40;

	localparam logic [4:0] ERR_PAD = 5'd1;
	localparam logic [4:0] ERR_LEN = 5'd2;
	localparam logic [4:0] ERR_MAL = 5'd4;
	localparam logic [4:0] ERR_DUP = 5'd8;
	localparam logic [4:0] ERR_UNK = 5'd16;

	localparam logic [7:0] OPT_EOL    = 8'h00;
	localparam logic [7:0] OPT_NOP    = 8'h01;
	localparam logic [7:0] OPT_RR     = 8'h07;
	localparam logic [7:0] OPT_QS     = 8'h19;
	localparam logic [7:0] OPT_TS     = 8'h44;
	localparam logic [7:0] OPT_SEC    = 8'h82;
	localparam logic [7:0] OPT_LSRR   = 8'h83;
	localparam logic [7:0] OPT_CIPSO  = 8'h86;
	localparam logic [7:0] OPT_SID    = 8'h88;
	localparam logic [7:0] OPT_SSRR   = 8'h89;
	localparam logic [7:0] OPT_RTRALT = 8'h94;

	typedef enum logic [2:0] {
		KIND_UNKNOWN,
		KIND_GENERIC,
		KIND_ROUTE,
		KIND_TS,
		KIND_CIPSO
	} opt_kind_t;

	typedef struct packed {
		logic [7:0] opt_byte;
		logic [5:0] area_len;
		logic       last;
	} in_word_t;

	typedef struct packed {
		logic [10:0] opts_seen;
		logic [5:0]  option_count;
		logic [4:0]  error_flags;
		logic        aborted;
	} out_word_t;

	typedef struct packed {
		logic [5:0]  area_left;
		logic [7:0]  cur_type;
		logic [7:0]  cur_len;
		logic [5:0]  byte_index;
		logic [7:0]  ptr_byte;
		logic [5:0]  tag_left;
		logic [1:0]  tag_phase;
		logic [7:0]  tag_type;
		logic [7:0]  tag_len;
		logic [10:0] seen;
		logic [5:0]  count;
		logic [4:0]  err;
		logic        stopped;
		logic        abort;
		logic        check_fail;
		logic        in_packet;
	} walk_state_t;

	// Bit position in opts_seen; 11 marks an unknown type.
	function automatic logic [3:0] opt_bit(input logic [7:0] t);
		unique case (t)
			OPT_RR:     opt_bit = 4'd2;
			OPT_QS:     opt_bit = 4'd3;
			OPT_TS:     opt_bit = 4'd4;
			OPT_SEC:    opt_bit = 4'd5;
			OPT_LSRR:   opt_bit = 4'd6;
			OPT_CIPSO:  opt_bit = 4'd7;
			OPT_SID:    opt_bit = 4'd8;
			OPT_SSRR:   opt_bit = 4'd9;
			OPT_RTRALT: opt_bit = 4'd10;
			default:    opt_bit = 4'd11;
		endcase
	endfunction

	function automatic opt_kind_t opt_kind(input logic [7:0] t);
		unique case (t) inside
			OPT_QS, OPT_SEC, OPT_SID, OPT_RTRALT: opt_kind = KIND_GENERIC;
			OPT_RR, OPT_LSRR, OPT_SSRR:           opt_kind = KIND_ROUTE;
			OPT_TS:                               opt_kind = KIND_TS;
			OPT_CIPSO:                            opt_kind = KIND_CIPSO;
			default:                              opt_kind = KIND_UNKNOWN;
		endcase
	endfunction

endpackage

// ===== hw/rtl/ipv4_option_validator_unit.sv =====
// IPv4 option validator.
// The input channel carries one word per options byte: the byte itself, the
// area length (sampled on the first byte of a packet) and a last marker.
// Words are accepted on any edge where in_valid is high and in_stall low.
// The output channel carries one summary word per packet, produced from the
// word marked last: option flags, an option count, an error mask and an
// abort flag.
// Each input word is registered, then walked by one pass of combinational
// logic whose result updates the walk state; the summary for a last word
// moves from the input register into the output register once that register
// is free, which raises out_valid, and the summary can be taken at the
// following edge at the earliest.
// Throughput is one word per cycle while in_stall is low; input and output
// registers are separated so a waiting summary does not block new bytes.
// If the receiver stalls while a summary waits and a new summary is due,
// the input stage holds its word and in_stall rises until space frees up.
// Reset clears the walk state, both valid flags and all counters; the
// block can take a word as soon as reset is released.
module ipv4_option_validator_unit
	import ipv4ov_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_data
);

	in_word_t    word_s1;
	logic        valid_s1;
	walk_state_t st_q;
	walk_state_t nx;
	logic        adv_s1;
	logic        out_free;

	// The output register is free when empty or being taken this cycle.
	assign out_free = !out_valid || !out_stall;
	// The registered word moves on unless it ends a packet and the output is full.
	assign adv_s1   = valid_s1 && (!word_s1.last || out_free);
	assign in_stall = valid_s1 && !adv_s1;

	ipv4ov_walk u_walk (
		.st   (st_q),
		.word (word_s1),
		.nx   (nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			word_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv_s1) begin
			if (word_s1.last) st_q <= '0;
			else st_q <= nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s1 && word_s1.last) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && word_s1.last) begin
			out_data.opts_seen    <= nx.seen;
			out_data.option_count <= nx.count;
			out_data.error_flags  <= nx.err;
			out_data.aborted      <= nx.abort;
		end
	end

endmodule

// ===== hw/rtl/ipv4ov_walk.sv =====
module ipv4ov_walk
	import ipv4ov_pkg::*;
(
	input  walk_state_t st,
	input  in_word_t    word,
	output walk_state_t nx
);

	always_comb begin
		logic [5:0]  alen;
		logic [7:0]  b;
		logic [3:0]  bit_pos;
		logic [8:0]  plen;
		logic [8:0]  len_p1;
		logic [7:0]  pm5;
		logic [3:0]  tsf;
		logic        fatal;
		logic        known;
		logic        acc;
		logic [4:0]  ferr;
		logic [10:0] onehot;

		nx     = st;
		b      = word.opt_byte;
		fatal  = 1'b0;
		acc    = 1'b0;
		ferr   = '0;
		bit_pos = opt_bit(st.cur_type);
		onehot = 11'(1) << bit_pos;
		len_p1 = {1'b0, st.cur_len} + 9'd1;
		pm5    = st.ptr_byte - 8'd5;
		tsf    = b[3:0];
		known  = 1'b0;
		plen   = '0;
		alen   = '0;

		if (!st.in_packet) begin
			nx.in_packet = 1'b1;
			alen = (word.area_len > 6'(MAX_OPT_BYTES)) ? 6'(MAX_OPT_BYTES) : word.area_len;
			nx.area_left = alen;
			if (alen[2:0] != 3'd0)
				nx.err = nx.err | ERR_PAD;
		end

		if (!nx.stopped && nx.area_left != 6'd0) begin
			if (st.byte_index == 6'd0) begin
				if (nx.count < 6'(MAX_OPT_BYTES))
					nx.count = nx.count + 6'd1;
				if (b == OPT_EOL) begin
					nx.seen[0] = 1'b1;
					nx.stopped = 1'b1;
				end else if (b == OPT_NOP) begin
					nx.seen[1]   = 1'b1;
					nx.area_left = nx.area_left - 6'd1;
				end else if (nx.area_left < 6'd2) begin
					nx.stopped = 1'b1;
				end else begin
					nx.cur_type   = b;
					nx.byte_index = 6'd1;
					nx.area_left  = nx.area_left - 6'd1;
				end
			end else if (st.byte_index == 6'd1) begin
				plen = {3'd0, nx.area_left} + 9'd1;
				nx.cur_len = b;
				if ({1'b0, b} > plen || b < 8'd2) begin
					fatal = 1'b1;
					ferr  = ERR_LEN;
				end else begin
					nx.area_left = nx.area_left - 6'd1;
					if (bit_pos > 4'd10) begin
						nx.err = nx.err | ERR_UNK;
						nx.check_fail = 1'b1;
					end else if ((st.seen & onehot) != '0) begin
						nx.err = nx.err | ERR_DUP;
						nx.check_fail = 1'b1;
					end else begin
						nx.check_fail = 1'b0;
						case (opt_kind(st.cur_type))
							KIND_GENERIC: begin
								if (st.cur_type == OPT_QS) fatal = b < 8'd8;
								else if (st.cur_type == OPT_SEC) fatal = b != 8'd11;
								else fatal = b != 8'd4;
								if (fatal) ferr = ERR_LEN;
								else acc = 1'b1;
							end
							KIND_ROUTE: begin
								fatal = b < 8'd3;
								ferr  = ERR_LEN;
							end
							KIND_TS: begin
								fatal = b < 8'd5;
								ferr  = ERR_LEN;
							end
							default: begin
								fatal = b < 8'd10;
								ferr  = ERR_LEN;
								nx.tag_left  = 6'(b - 8'd6);
								nx.tag_phase = 2'd0;
							end
						endcase
					end
					nx.byte_index = (b > 8'd2) ? 6'd2 : 6'd0;
				end
			end else begin
				nx.area_left = nx.area_left - 6'd1;
				if (!st.check_fail) begin
					case (opt_kind(st.cur_type))
						KIND_ROUTE: begin
							if (st.byte_index == 6'd2) begin
								if (b < 8'd4 || b[1:0] != 2'd0 || {1'b0, b} > len_p1) begin
									fatal = 1'b1;
									ferr  = ERR_MAL;
								end else acc = 1'b1;
							end
						end
						KIND_TS: begin
							if (st.byte_index == 6'd2) begin
								if (b < 8'd5) begin
									fatal = 1'b1;
									ferr  = ERR_MAL;
								end else nx.ptr_byte = b;
							end else if (st.byte_index == 6'd3) begin
								if (((tsf == 4'd1 || tsf == 4'd3) ? (pm5[2:0] != 3'd0)
									: (pm5[1:0] != 2'd0)) || {1'b0, st.ptr_byte} > len_p1) begin
									fatal = 1'b1;
									ferr  = ERR_MAL;
								end else acc = 1'b1;
							end
						end
						KIND_CIPSO: begin
							if (st.byte_index >= 6'd6) begin
								case (st.tag_phase)
									2'd0: begin
										if (st.tag_left < 6'd2) begin
											fatal = 1'b1;
											ferr  = ERR_MAL;
										end else begin
											nx.tag_type  = b;
											nx.tag_phase = 2'd1;
										end
									end
									2'd1: begin
										known = st.tag_type == 8'd1 || st.tag_type == 8'd2 ||
											st.tag_type == 8'd5 || st.tag_type == 8'd6 ||
											st.tag_type == 8'd7;
										if (b > {2'd0, st.tag_left} || !known || b < 8'd4) begin
											fatal = 1'b1;
											ferr  = ERR_MAL;
										end else begin
											nx.tag_len   = b;
											nx.tag_phase = 2'd2;
										end
									end
									2'd2: begin
										if (st.tag_type != 8'd7 && b != 8'd0) begin
											fatal = 1'b1;
											ferr  = ERR_MAL;
										end else begin
											nx.tag_left  = st.tag_left - st.tag_len[5:0];
											nx.tag_len   = st.tag_len - 8'd3;
											nx.tag_phase = 2'd3;
										end
									end
									default: begin
										nx.tag_len = st.tag_len - 8'd1;
										if (nx.tag_len == 8'd0) begin
											nx.tag_phase = 2'd0;
											if (st.tag_left == 6'd0) acc = 1'b1;
										end
									end
								endcase
							end
						end
						default: ;
					endcase
				end
				if ({2'd0, st.byte_index} + 8'd1 >= st.cur_len) nx.byte_index = 6'd0;
				else nx.byte_index = st.byte_index + 6'd1;
			end
			if (fatal) begin
				nx.err     = nx.err | ferr;
				nx.abort   = 1'b1;
				nx.stopped = 1'b1;
			end
			if (acc) begin
				nx.seen = nx.seen | onehot;
				nx.check_fail = 1'b1;
			end
		end
	end

endmodule

// ===== dv/ipv4_option_validator_unit_test.sv =====
`timescale 1ns / 1ps

// Testbench for the IPv4 option validator. Packets of option bytes are sent
// one word per accepted handshake. A predictor walks every byte the same way
// the block should, and on each last word it queues the summary word that
// the block must produce. A checker process pops that queue for every
// accepted output word and compares it field by field.
module ipv4_option_validator_unit_test;
	import ipv4ov_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_word_t out_data;

	ipv4_option_validator_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial clk = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor state. It mirrors the walk of the options area.
	logic [5:0]  pr_area_left;
	logic [7:0]  pr_type;
	logic [7:0]  pr_len;
	logic [5:0]  pr_index;
	logic [7:0]  pr_ptr;
	logic [5:0]  pr_tag_left;
	logic [2:0]  pr_tag_phase;
	logic [7:0]  pr_tag_type;
	logic [7:0]  pr_tag_len;
	logic [10:0] pr_seen;
	logic [5:0]  pr_count;
	logic [4:0]  pr_err;
	logic        pr_stopped;
	logic        pr_abort;
	logic        pr_skip;
	logic        pr_in_packet;

	out_word_t summary_q[$];
	int        mismatches;
	bit        stall_free;

	task automatic clear_walk();
		pr_area_left = '0;
		pr_type = '0;
		pr_len = '0;
		pr_index = '0;
		pr_ptr = '0;
		pr_tag_left = '0;
		pr_tag_phase = '0;
		pr_tag_type = '0;
		pr_tag_len = '0;
		pr_seen = '0;
		pr_count = '0;
		pr_err = '0;
		pr_stopped = 1'b0;
		pr_abort = 1'b0;
		pr_skip = 1'b0;
		pr_in_packet = 1'b0;
	endtask

	function automatic int flag_pos(logic [7:0] t);
		case (t)
			OPT_RR:     return 2;
			OPT_QS:     return 3;
			OPT_TS:     return 4;
			OPT_SEC:    return 5;
			OPT_LSRR:   return 6;
			OPT_CIPSO:  return 7;
			OPT_SID:    return 8;
			OPT_SSRR:   return 9;
			OPT_RTRALT: return 10;
			default:    return 11;
		endcase
	endfunction

	function automatic opt_kind_t kind_of(logic [7:0] t);
		case (t) inside
			OPT_QS, OPT_SEC, OPT_SID, OPT_RTRALT: return KIND_GENERIC;
			OPT_RR, OPT_LSRR, OPT_SSRR:           return KIND_ROUTE;
			OPT_TS:                               return KIND_TS;
			OPT_CIPSO:                            return KIND_CIPSO;
			default:                              return KIND_UNKNOWN;
		endcase
	endfunction

	task automatic raise_fatal(logic [4:0] bitv);
		pr_err |= bitv;
		pr_abort = 1'b1;
		pr_stopped = 1'b1;
	endtask

	task automatic mark_valid();
		pr_seen[flag_pos(pr_type)] = 1'b1;
		pr_skip = 1'b1;
	endtask

	task automatic judge_len();
		int pos;
		logic bad;
		pos = flag_pos(pr_type);
		if (pos > 10) begin
			pr_err |= ERR_UNK;
			pr_skip = 1'b1;
			return;
		end
		if (pr_seen[pos]) begin
			pr_err |= ERR_DUP;
			pr_skip = 1'b1;
			return;
		end
		pr_skip = 1'b0;
		case (kind_of(pr_type))
			KIND_GENERIC: begin
				if (pr_type == OPT_QS) bad = pr_len < 8;
				else if (pr_type == OPT_SEC) bad = pr_len != 11;
				else bad = pr_len != 4;
				if (bad) raise_fatal(ERR_LEN);
				else mark_valid();
			end
			KIND_ROUTE: if (pr_len < 3) raise_fatal(ERR_LEN);
			KIND_TS:    if (pr_len < 5) raise_fatal(ERR_LEN);
			default: begin
				if (pr_len < 10) raise_fatal(ERR_LEN);
				else begin
					pr_tag_left = 6'(pr_len - 8'd6);
					pr_tag_phase = '0;
				end
			end
		endcase
	endtask

	// One byte of the CIPSO tag chain: tag type, tag length, alignment
	// octet, then the tag body.
	task automatic cipso_tag_byte(logic [7:0] b);
		logic known;
		case (pr_tag_phase)
			3'd0: begin
				if (pr_tag_left < 2) raise_fatal(ERR_MAL);
				else begin
					pr_tag_type = b;
					pr_tag_phase = 3'd1;
				end
			end
			3'd1: begin
				known = pr_tag_type inside {8'd1, 8'd2, 8'd5, 8'd6, 8'd7};
				if (b > pr_tag_left || !known || b < 4) raise_fatal(ERR_MAL);
				else begin
					pr_tag_len = b;
					pr_tag_phase = 3'd2;
				end
			end
			3'd2: begin
				if (pr_tag_type != 8'd7 && b != 8'd0) raise_fatal(ERR_MAL);
				else begin
					pr_tag_left = pr_tag_left - 6'(pr_tag_len);
					pr_tag_len = pr_tag_len - 8'd3;
					pr_tag_phase = 3'd3;
				end
			end
			default: begin
				pr_tag_len = pr_tag_len - 8'd1;
				if (pr_tag_len == 0) begin
					pr_tag_phase = 3'd0;
					if (pr_tag_left == 0) mark_valid();
				end
			end
		endcase
	endtask

	task automatic option_data(logic [7:0] b);
		int sz;
		logic [3:0] flag;
		case (kind_of(pr_type))
			KIND_ROUTE: begin
				if (pr_index == 2) begin
					if (b < 4 || b[1:0] != 2'd0 || 9'(b) > 9'(pr_len) + 9'd1)
						raise_fatal(ERR_MAL);
					else mark_valid();
				end
			end
			KIND_TS: begin
				if (pr_index == 2) begin
					if (b < 5) raise_fatal(ERR_MAL);
					else pr_ptr = b;
				end else if (pr_index == 3) begin
					flag = b[3:0];
					sz = (flag == 4'd1 || flag == 4'd3) ? 8 : 4;
					// The pointer was checked to be at least 5 above.
					if (((int'(pr_ptr) - 5) % sz) != 0 ||
						9'(pr_ptr) > 9'(pr_len) + 9'd1)
						raise_fatal(ERR_MAL);
					else mark_valid();
				end
			end
			KIND_CIPSO: if (pr_index >= 6) cipso_tag_byte(b);
			default: ;
		endcase
	endtask

	task automatic walk_byte(logic [7:0] b);
		if (pr_index == 0) begin
			if (pr_count < MAX_OPT_BYTES) pr_count++;
			if (b == OPT_EOL) begin
				pr_seen[0] = 1'b1;
				pr_stopped = 1'b1;
			end else if (b == OPT_NOP) begin
				pr_seen[1] = 1'b1;
				pr_area_left--;
			end else if (pr_area_left < 2) begin
				// A lone type byte at the tail ends the walk quietly.
				pr_stopped = 1'b1;
			end else begin
				pr_type = b;
				pr_index = 6'd1;
				pr_area_left--;
			end
		end else if (pr_index == 1) begin
			pr_len = b;
			if (9'(b) > 9'(pr_area_left) + 9'd1 || b < 2) raise_fatal(ERR_LEN);
			else begin
				pr_area_left--;
				judge_len();
				pr_index = (pr_len > 2) ? 6'd2 : 6'd0;
			end
		end else begin
			pr_area_left--;
			if (!pr_skip) option_data(b);
			if (9'(pr_index) + 9'd1 >= 9'(pr_len)) pr_index = '0;
			else pr_index++;
		end
	endtask

	// Feeds one accepted word to the predictor and queues a summary on last.
	task automatic predict_word(in_word_t w);
		logic [5:0] alen;
		out_word_t s;
		if (!pr_in_packet) begin
			pr_in_packet = 1'b1;
			alen = (w.area_len > MAX_OPT_BYTES) ? 6'(MAX_OPT_BYTES) : w.area_len;
			pr_area_left = alen;
			if (alen[2:0] != 3'd0) pr_err |= ERR_PAD;
		end
		if (!pr_stopped && pr_area_left > 0) walk_byte(w.opt_byte);
		if (w.last) begin
			s.opts_seen = pr_seen;
			s.option_count = pr_count;
			s.error_flags = pr_err;
			s.aborted = pr_abort;
			summary_q.push_back(s);
			clear_walk();
		end
	endtask

	// Sends one word after a random gap and waits until it is accepted.
	// Valid stays high after acceptance, so a gap of zero gives back to
	// back words.
	task automatic send_word(logic [7:0] b, logic [5:0] alen, logic fin);
		int gap;
		gap = stall_free ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{opt_byte: b, area_len: alen, last: fin};
		do @(posedge clk); while (in_stall);
		predict_word('{opt_byte: b, area_len: alen, last: fin});
	endtask

	// Sends a whole packet; the last byte carries the last marker.
	task automatic send_packet(logic [7:0] bytes[$], logic [5:0] alen);
		foreach (bytes[i]) send_word(bytes[i], alen, i == bytes.size() - 1);
	endtask

	// The receiver stalls for a random number of cycles before each output
	// word, then takes it.
	initial begin
		int hold;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			hold = stall_free ? 0 : $urandom_range(0, 7);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Checker: every accepted summary word is compared with the oldest
	// expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (summary_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected summary word %h", out_data);
			end else begin
				out_word_t e;
				e = summary_q.pop_front();
				if (e.opts_seen !== out_data.opts_seen ||
					e.option_count !== out_data.option_count ||
					e.error_flags !== out_data.error_flags ||
					e.aborted !== out_data.aborted) begin
					mismatches++;
					if (mismatches <= 10)
						$display("summary mismatch: seen %h/%h count %0d/%0d err %h/%h abort %b/%b",
							e.opts_seen, out_data.opts_seen,
							e.option_count, out_data.option_count,
							e.error_flags, out_data.error_flags,
							e.aborted, out_data.aborted);
				end
			end
		end
	end

	// Directed packets: every option type but LSRR and SSRR well formed, the fatal length and
	// pointer cases, duplicates, unknown types, lone type byte, short and
	// long areas, and an oversized area length.
	task automatic test_directed();
		send_packet('{OPT_EOL}, 6'd1);
		send_packet('{OPT_NOP, OPT_NOP, OPT_NOP, OPT_EOL, 8'hFF, 8'hAA, 8'h00, 8'h00}, 6'd8);
		send_packet('{OPT_RR, 8'd7, 8'd4, 8'd1, 8'd2, 8'd3, 8'd4, OPT_EOL}, 6'd8);
		send_packet('{OPT_TS, 8'd12, 8'd5, 8'h01, 8'd0, 8'd0, 8'd0, 8'd0,
			8'd0, 8'd0, 8'd0, 8'd0, OPT_EOL, 8'd0, 8'd0, 8'd0}, 6'd16);
		send_packet('{OPT_TS, 8'd8, 8'd9, 8'hF0, 8'd0, 8'd0, 8'd0, 8'd0}, 6'd8);
		send_packet('{OPT_CIPSO, 8'd14, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd8,
			8'd0, 8'd5, 8'd1, 8'd2, 8'd3, 8'd4, OPT_EOL, 8'd0}, 6'd16);
		send_packet('{OPT_CIPSO, 8'd10, 8'd0, 8'd0, 8'd0, 8'd1, 8'd3, 8'd4,
			8'd0, 8'd0}, 6'd10);
		send_packet('{OPT_SID, 8'd4, 8'd1, 8'd2, OPT_SID, 8'd4, 8'd1, 8'd2}, 6'd8);
		send_packet('{OPT_SEC, 8'd11, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
			8'd0, 8'd0, 8'd0, OPT_QS, 8'd8, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
			8'd0, OPT_RTRALT, 8'd4, 8'd0, 8'd0, OPT_EOL}, 6'd24);
		send_packet('{8'hEE, 8'd3, 8'h55, OPT_RTRALT, 8'd5, 8'd0, 8'd0, 8'd0}, 6'd8);
		send_packet('{OPT_LSRR, 8'd9, 8'd4}, 6'd8);
		send_packet('{OPT_SSRR, 8'd7, 8'd5, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}, 6'd8);
		send_packet('{OPT_NOP, OPT_NOP, OPT_SID}, 6'd3);
		send_packet('{OPT_QS, 8'd1, 8'd0}, 6'd2);
		send_packet('{OPT_NOP, OPT_NOP, OPT_NOP, OPT_NOP, OPT_NOP, 8'hAB}, 6'd63);
		send_packet('{8'hFF}, 6'd0);
	endtask

	// Builds one option, mostly well formed, or a NOP; sometimes a byte is corrupted.
	task automatic build_option(ref logic [7:0] bytes[$], input int room);
		int pick;
		int len;
		int k;
		logic [7:0] t;
		pick = $urandom_range(0, 9);
		case (pick)
			0: begin bytes.push_back(OPT_NOP); return; end
			1, 2: begin
				t = (pick == 1) ? OPT_SID : OPT_RTRALT;
				len = 4;
			end
			3: begin t = OPT_SEC; len = 11; end
			4: begin t = OPT_QS; len = $urandom_range(8, 12); end
			5: begin
				case ($urandom_range(0, 2))
					0: t = OPT_RR;
					1: t = OPT_LSRR;
					default: t = OPT_SSRR;
				endcase
				len = 3 + 4 * $urandom_range(0, 3);
			end
			6: begin t = OPT_TS; len = 4 + 4 * $urandom_range(1, 4); end
			7: begin t = OPT_CIPSO; len = 6 + 4 * $urandom_range(1, 3); end
			default: begin t = 8'($urandom_range(0, 255)); len = $urandom_range(2, 8); end
		endcase
		if (len > room) begin
			bytes.push_back(OPT_NOP);
			return;
		end
		bytes.push_back(t);
		bytes.push_back(8'(len));
		if (t == OPT_CIPSO) begin
			for (k = 0; k < 4; k++) bytes.push_back(8'($urandom));
			// One tag covering the whole tag area.
			bytes.push_back(8'd7);
			bytes.push_back(8'(len - 6));
			for (k = 2; k < len - 6; k++) bytes.push_back(8'($urandom));
		end else begin
			for (k = 2; k < len; k++) begin
				if (k == 2 && kind_of(t) == KIND_ROUTE)
					bytes.push_back(8'(4 * $urandom_range(1, (len + 1) / 4)));
				else if (k == 2 && t == OPT_TS)
					bytes.push_back(8'(5 + 4 * $urandom_range(0, (len - 4) / 4)));
				else if (k == 3 && t == OPT_TS)
					bytes.push_back({4'($urandom), 4'($urandom_range(0, 1) ? 0 : 1)});
				else bytes.push_back(8'($urandom));
			end
		end
		if ($urandom_range(0, 15) == 0)
			bytes[bytes.size() - 1 - $urandom_range(0, len - 1)] = 8'($urandom);
	endtask

	task automatic test_random(int word_goal);
		logic [7:0] bytes[$];
		int sent;
		int alen;
		int mode;
		sent = 0;
		while (sent < word_goal) begin
			bytes.delete();
			alen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
				: 8 * $urandom_range(1, 5);
			mode = $urandom_range(0, 9);
			if (mode < 7) begin
				while (bytes.size() < alen && bytes.size() < 40)
					build_option(bytes, ((alen > 40) ? 40 : alen) - bytes.size());
				if ($urandom_range(0, 3) == 0) bytes.push_back(OPT_EOL);
			end else begin
				repeat ($urandom_range(1, 44)) bytes.push_back(8'($urandom));
			end
			// Short and long areas relative to area_len.
			if (mode == 6 && bytes.size() > 1)
				bytes = bytes[0:$urandom_range(0, bytes.size() - 2)];
			if (bytes.size() == 0) bytes.push_back(8'($urandom));
			stall_free = ($urandom_range(0, 7) == 0);
			send_packet(bytes, 6'(alen));
			sent += bytes.size();
		end
		stall_free = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		mismatches = 0;
		stall_free = 1'b0;
		clear_walk();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(1500);
		in_valid <= 1'b0;
		while (summary_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && summary_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog against a stuck handshake.
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== ipv4_option_validator_unit.f =====
hw/rtl/ipv4ov_pkg.sv
hw/rtl/ipv4ov_walk.sv
hw/rtl/ipv4_option_validator_unit.sv
dv/ipv4_option_validator_unit_test.sv
